/* rtl/tlc_pkg.sv */
// shared types and constants of the two-way lru cache tag lookup
// no dependencies; used by tlc_set_ram, tlc_way_select and the top level
package tlc_pkg;

   localparam int ADDR_W      = 32;
   localparam int OFFSET_W    = 5;
   localparam int BLOCK_W     = 27;
   localparam int SET_FIELD_W = 6;
   localparam int TAG_W       = 21;
   localparam int CNT_W       = 32;
   localparam int PAD_W       = 5;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // one memory row holds a whole set
   typedef struct packed {
      logic                       recent;
      logic [1:0]                 valid;
      logic [1:0][TAG_W-1:0]      tag;
   } set_row_type;

   // outcome of comparing one reference against its set
   typedef struct packed {
      logic                       way;
      logic                       miss;
      logic                       repl;
      logic [TAG_W-1:0]           evicted;
      set_row_type                new_row;
   } lookup_type;

   // result transaction, last field in the lowest bits
   typedef struct packed {
      logic [PAD_W-1:0]           pad;
      logic [CNT_W-1:0]           miss_total;
      logic [CNT_W-1:0]           hit_total;
      logic [TAG_W-1:0]           evicted_tag;
      logic                       replaced_valid;
      logic                       is_miss;
      logic [TAG_W-1:0]           line_tag;
      logic                       way_used;
      logic [SET_FIELD_W-1:0]     set_index;
      logic [BLOCK_W-1:0]         block_number;
      logic [OFFSET_W-1:0]        byte_offset;
   } rsp_type;

endpackage

/* rtl/tlc_set_ram.sv */
// set memory: one row per set with both tags, valid bits and lru bit
// registered read, one write port, clearing pass after reset
// depends on tlc_pkg
module tlc_set_ram #(
   parameter int NUM_SETS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rd_en,
   input  logic [$clog2(NUM_SETS)-1:0]     rd_addr,
   output tlc_pkg::set_row_type            rd_data,
   input  logic                            wr_en,
   input  logic [$clog2(NUM_SETS)-1:0]     wr_addr,
   input  tlc_pkg::set_row_type            wr_data,
   output logic                            clr_busy
);

   localparam int SET_W = $clog2(NUM_SETS);

   tlc_pkg::set_row_type mem [NUM_SETS];
   tlc_pkg::set_row_type rd_data_ff;
   tlc_pkg::set_row_type clr_row;

   logic [SET_W-1:0] clr_idx_ff, clr_idx_in;
   logic             clr_busy_ff, clr_busy_in;
   logic             mem_we;
   logic [SET_W-1:0] mem_wa;
   tlc_pkg::set_row_type mem_wd;

   always_comb begin
      clr_row        = '0;
      clr_row.recent = 1'b1;   // way zero is filled first
      clr_idx_in     = clr_idx_ff;
      clr_busy_in    = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == SET_W'(NUM_SETS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      mem_we = clr_busy_ff | wr_en;
      mem_wa = clr_busy_ff ? clr_idx_ff : wr_addr;
      mem_wd = clr_busy_ff ? clr_row : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_idx_ff  <= clr_idx_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

/* rtl/tlc_way_select.sv */
// tag compare, hit way / victim choice and updated set row
// depends on tlc_pkg
module tlc_way_select (
   input  tlc_pkg::set_row_type           row,
   input  logic [tlc_pkg::TAG_W-1:0]      tag,
   output tlc_pkg::lookup_type            lookup
);

   logic hit0;
   logic hit1;
   logic miss;
   logic way;

   always_comb begin
      hit0 = row.valid[0] && (row.tag[0] == tag);
      hit1 = !hit0 && row.valid[1] && (row.tag[1] == tag);
      miss = !hit0 && !hit1;
      // on a miss the way that was not used last is the victim
      way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : ~row.recent);

      lookup.way     = way;
      lookup.miss    = miss;
      lookup.repl    = miss && row.valid[way];
      lookup.evicted = (miss && row.valid[way]) ? row.tag[way] : '0;

      lookup.new_row        = row;
      lookup.new_row.recent = way;
      if (miss) begin
         lookup.new_row.valid[way] = 1'b1;
         lookup.new_row.tag[way]   = tag;
      end
   end

endmodule

/* rtl/two_way_lru_cache_tag_lookup_core.sv */
// two-way set-associative cache tag lookup with lru replacement
// depends on tlc_pkg, tlc_set_ram and tlc_way_select
//
// req channel: one 32-bit byte address per transaction on req_tdata.
// rsp channel: one result per address: offset, block, set, way, tag,
// miss and eviction flags, evicted tag and saturating hit/miss totals.
// NUM_SETS and LINE_BYTES are powers of two.
// the set row is read from the set memory at the edge that takes the
// address; in the compare state the tags are compared, the row is
// written back and the result is loaded into the output register. a
// new request is not taken until the row is written back, because of
// the read-modify-write of the set memory.
// the output register lets a new request be taken while a result waits;
// the compare stage holds while the output register is full and stalled.
// reset clears counters and control state and starts a clearing pass
// over the set memory (valid bits off, way zero next); req_tready stays
// low until it ends.
module two_way_lru_cache_tag_lookup_core #(
   parameter int NUM_SETS   = 64,
   parameter int LINE_BYTES = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,    // address
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata     // byte_offset, block_number, set_index, way_used,
                                      // line_tag, is_miss, replaced_valid, evicted_tag,
                                      // hit_total, miss_total, zero fill
);

   localparam int OFF_W = $clog2(LINE_BYTES);
   localparam int SET_W = $clog2(NUM_SETS);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic state_ff, state_in;
   logic [tlc_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [tlc_pkg::CNT_W-1:0]  hit_ff, hit_in;
   logic [tlc_pkg::CNT_W-1:0]  miss_ff, miss_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tlc_pkg::rsp_type           rsp_ff, rsp_in;

   logic [tlc_pkg::ADDR_W-1:0] req_block;
   logic [tlc_pkg::ADDR_W-1:0] cur_block;
   logic [tlc_pkg::ADDR_W-1:0] cur_tag_full;
   logic [SET_W-1:0]           req_set;
   logic [SET_W-1:0]           cur_set;
   logic [tlc_pkg::TAG_W-1:0]  cur_tag;

   logic                       req_fire;
   logic                       upd_fire;
   logic                       ram_busy;
   tlc_pkg::set_row_type       row;
   tlc_pkg::lookup_type        lookup;

   assign req_block    = req_tdata >> OFF_W;
   assign req_set      = req_block[SET_W-1:0];
   assign cur_block    = addr_ff >> OFF_W;
   assign cur_set      = cur_block[SET_W-1:0];
   assign cur_tag_full = cur_block >> SET_W;
   assign cur_tag      = cur_tag_full[tlc_pkg::TAG_W-1:0];

   assign req_tready = (state_ff == ST_IDLE) && !ram_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign upd_fire   = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_tready);

   tlc_set_ram #(
      .NUM_SETS (NUM_SETS)
   ) u_set_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (req_set),
      .rd_data  (row),
      .wr_en    (upd_fire),
      .wr_addr  (cur_set),
      .wr_data  (lookup.new_row),
      .clr_busy (ram_busy)
   );

   tlc_way_select u_way_select (
      .row    (row),
      .tag    (cur_tag),
      .lookup (lookup)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               addr_in  = req_tdata;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               if (lookup.miss) begin
                  if (miss_ff != tlc_pkg::CNT_MAX) begin
                     miss_in = miss_ff + 1'b1;
                  end
               end else if (hit_ff != tlc_pkg::CNT_MAX) begin
                  hit_in = hit_ff + 1'b1;
               end
               rsp_in.pad            = '0;
               rsp_in.byte_offset    = tlc_pkg::OFFSET_W'(addr_ff[OFF_W-1:0]);
               rsp_in.block_number   = cur_block[tlc_pkg::BLOCK_W-1:0];
               rsp_in.set_index      = tlc_pkg::SET_FIELD_W'(cur_set);
               rsp_in.way_used       = lookup.way;
               rsp_in.line_tag       = cur_tag;
               rsp_in.is_miss        = lookup.miss;
               rsp_in.replaced_valid = lookup.repl;
               rsp_in.evicted_tag    = lookup.evicted;
               rsp_in.hit_total      = hit_in;
               rsp_in.miss_total     = miss_in;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hit_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // a taken request always moves on to the compare stage
   a_req_to_update : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_UPDATE))
      else $error("request transaction did not reach the compare stage");

   // a hit never reports an eviction
   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.is_miss) |->
         (!rsp_ff.replaced_valid && (rsp_ff.evicted_tag == '0)))
      else $error("hit result carries an eviction");

   // totals only grow, and by at most one per lookup
   a_counts_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((hit_ff >= $past(hit_ff)) && (miss_ff >= $past(miss_ff))
         && ((hit_ff - $past(hit_ff)) + (miss_ff - $past(miss_ff)) <= 1)))
      else $error("hit or miss total moved wrongly");

   // no lookup while the clearing pass runs
   a_no_req_while_clearing : assert property (@(posedge clock) disable iff (reset)
      ram_busy |-> !req_fire)
      else $error("request taken during the clearing pass");

endmodule
